/* design/dfc_pkg.sv */
// dfc_pkg: shared types, result codes and the checksum fold for the frame deframer/checker
// depends on nothing; used by dfc_parser and data_frame_deframer_checker_core
`timescale 1ns / 1ps

package dfc_pkg;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   localparam int unsigned HEADER_LAST = 7;

   typedef struct packed {
      logic        valid;
      logic [1:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [9:0]  payload_index;
      logic [31:0] sequence_number;
      logic [31:0] payload_length;
      logic        last_frame;
      logic        checksum_bad;
   } result_type;

   // signed byte add into the 17-bit sum, end-around carry when it leaves 0..0xffff
   function automatic logic [16:0] sum_add(input logic [16:0] sum, input logic [7:0] b);
      logic [17:0] t;
      t = {1'b0, sum} + {{10{b[7]}}, b};
      if (t[17:16] != 2'b00) begin
         sum_add = {1'b0, t[15:0]} + 17'd1;
      end else begin
         sum_add = t[16:0];
      end
   endfunction

endpackage

/* design/dfc_parser.sv */
// dfc_parser: frame parsing state machine, header shift registers and running checksum
// depends on dfc_pkg; produces at most one result per accepted request byte
`timescale 1ns / 1ps

module dfc_parser #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          byte_in,
   output dfc_pkg::result_type result
);

   localparam int unsigned CountW = $clog2(MAX_PAYLOAD + 1);

   dfc_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         header_count_ff, header_count_in;
   logic [CountW-1:0]  payload_count_ff, payload_count_in;
   logic [CountW-1:0]  payload_count_inc;
   logic [31:0]        seq_shift_ff, seq_shift_in;
   logic [31:0]        length_shift_ff, length_shift_in;
   logic [16:0]        check_sum_ff, check_sum_in;
   logic               final_flag_ff, final_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dfc_pkg::PH_FLAG;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff  <= '0;
         payload_count_ff <= '0;
         seq_shift_ff     <= '0;
         length_shift_ff  <= '0;
         check_sum_ff     <= '0;
         final_flag_ff    <= 1'b0;
      end else begin
         header_count_ff  <= header_count_in;
         payload_count_ff <= payload_count_in;
         seq_shift_ff     <= seq_shift_in;
         length_shift_ff  <= length_shift_in;
         check_sum_ff     <= check_sum_in;
         final_flag_ff    <= final_flag_in;
      end
   end

   assign payload_count_inc = payload_count_ff + CountW'(1);

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      payload_count_in = payload_count_ff;
      seq_shift_in     = seq_shift_ff;
      length_shift_in  = length_shift_ff;
      check_sum_in     = check_sum_ff;
      final_flag_in    = final_flag_ff;

      result                 = '0;
      result.sequence_number = seq_shift_ff;
      result.payload_length  = length_shift_ff;
      result.last_frame      = final_flag_ff;

      if (accept) begin
         unique case (phase_ff)
            dfc_pkg::PH_FLAG: begin
               header_count_in  = '0;
               payload_count_in = '0;
               seq_shift_in     = '0;
               length_shift_in  = '0;
               final_flag_in    = (byte_in == 8'd0);
               check_sum_in     = dfc_pkg::sum_add(17'd0, byte_in);
               phase_in         = dfc_pkg::PH_HEADER;
            end
            dfc_pkg::PH_HEADER: begin
               check_sum_in = dfc_pkg::sum_add(check_sum_ff, byte_in);
               if (!header_count_ff[2]) begin
                  seq_shift_in = {seq_shift_ff[23:0], byte_in};
               end else begin
                  length_shift_in = {length_shift_ff[23:0], byte_in};
               end
               header_count_in = header_count_ff + 3'd1;
               if (header_count_ff == 3'(dfc_pkg::HEADER_LAST)) begin
                  if (length_shift_in > 32'(MAX_PAYLOAD)) begin
                     result.valid           = 1'b1;
                     result.result_kind     = dfc_pkg::KIND_REJECT;
                     result.sequence_number = seq_shift_in;
                     result.payload_length  = length_shift_in;
                     phase_in               = dfc_pkg::PH_FLAG;
                  end else begin
                     payload_count_in = '0;
                     phase_in = (length_shift_in == 32'd0) ? dfc_pkg::PH_CHECK
                                                           : dfc_pkg::PH_PAYLOAD;
                  end
               end
            end
            dfc_pkg::PH_PAYLOAD: begin
               check_sum_in         = dfc_pkg::sum_add(check_sum_ff, byte_in);
               result.valid         = 1'b1;
               result.result_kind   = dfc_pkg::KIND_PAYLOAD;
               result.payload_byte  = byte_in;
               result.payload_index = 10'(payload_count_ff);
               payload_count_in     = payload_count_inc;
               if (32'(payload_count_inc) >= length_shift_ff) begin
                  phase_in = dfc_pkg::PH_CHECK;
               end
            end
            dfc_pkg::PH_CHECK: begin
               result.valid        = 1'b1;
               result.result_kind  = dfc_pkg::KIND_STATUS;
               result.checksum_bad = (byte_in != check_sum_ff[7:0]);
               phase_in            = dfc_pkg::PH_FLAG;
            end
         endcase
      end
   end

endmodule

/* design/data_frame_deframer_checker_core.sv */
// data_frame_deframer_checker_core: top level of the frame deframer and checksum checker
// depends on dfc_pkg and dfc_parser; holds the output register and the stall logic
// output timing: a result appears on rsp_valid in the cycle after its request byte is accepted
// throughput: one request byte per cycle; req_stall rises only while the output
// register holds a result and rsp_stall is high
// reset: synchronous, clears the parser to await a flag byte and empties the output register
`timescale 1ns / 1ps

module data_frame_deframer_checker_core #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [9:0]  rsp_payload_index,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_payload_length,
   output logic        rsp_last_frame,
   output logic        rsp_checksum_bad
);

   logic                accept;
   dfc_pkg::result_type result;
   dfc_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   dfc_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .byte_in(req_byte_in),
      .result (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (result.valid) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_ff.result_kind;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_payload_index   = rsp_ff.payload_index;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_payload_length  = rsp_ff.payload_length;
   assign rsp_last_frame      = rsp_ff.last_frame;
   assign rsp_checksum_bad    = rsp_ff.checksum_bad;

   // input only held back by a full, stalled output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a pending stalled response");

   // mismatch flag only on frame status
   a_bad_only_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != dfc_pkg::KIND_STATUS) |-> !rsp_checksum_bad)
      else $error("checksum_bad set on a non-status response");

   // rejection only for lengths over the limit
   a_reject_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == dfc_pkg::KIND_REJECT)
         |-> (rsp_payload_length > 32'(MAX_PAYLOAD)))
      else $error("length rejected within the payload limit");

endmodule
